@@ design/iids_pkg.sv @@
// Package for the indexed insert/delete stack.
// Holds the command and status codes and the controller/datapath interface types.
// No dependencies.
`default_nettype none

package iids_pkg;

  // Command codes carried on the input channel.
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  // Status codes carried on the result channel.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;       // latch the accepted input transfer
    logic start;     // load the move pointers for the latched command
    logic pop_rd;    // read the top entry for a pop
    logic shift_rd;  // read one entry of a move sequence
    logic place;     // write the new word at its final address
    logic finish;    // commit the count and load the result registers
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] status;     // outcome of the latched command
    logic       is_put;     // push or insert
    logic       is_pop;     // plain pop
    logic       no_moves;   // no entries need to move
    logic       last_move;  // the current move read is the final one
  } dp_stat_t;

endpackage

`default_nettype wire

@@ design/indexed_insert_delete_stack.sv @@
// Top level of the indexed insert/delete stack.
// Instantiates iids_ctrl and iids_datapath; uses iids_pkg for interface types.
`default_nettype none

// Bounded LIFO stack of signed 32-bit words, position 0 being the top, with push,
// pop, insert at a position and remove at a position. Every accepted command gives
// one result with a status and the entry count after the command. The entries sit
// in a memory with a read and a write port, the bottom at address 0, so inserting
// or removing at position p moves p entries, one per cycle through the ports. A pop,
// a remove at the top or any command that ends in an error goes from evaluation
// straight to the result; a remove or an insert at a deeper position first moves
// its entries and drains the last write; a push or an insert then places the new
// word. The block is ready for the next command once the result is loaded. The
// result waits in an output register, and the block goes on with the next command
// while it waits; that command holds in its last step until the held result has
// been taken. The memory needs no clearing after reset; count and control state
// are reset.
module indexed_insert_delete_stack #(
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic signed [31:0] in_value,
  input  wire logic [4:0]         in_position,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic signed [31:0]      out_popped_value,
  output logic [1:0]              out_status,
  output logic [4:0]              out_count
);
  import iids_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Command sequencer.
  iids_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  // Storage and arithmetic.
  iids_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .in_position      (in_position),
    .dp_cmd           (dp_cmd),
    .dp_stat          (dp_stat),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_count        (out_count)
  );

  // The controller issues at most one sequencing command per cycle; the pop read comes with start.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({dp_cmd.cap, dp_cmd.start, dp_cmd.shift_rd, dp_cmd.place, dp_cmd.finish}))
    else $error("controller issued overlapping datapath commands");

  // A held result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.finish |-> !(out_valid && out_stall))
    else $error("result register loaded while a result was still held");

  // An accepted transfer is evaluated in the next cycle.
  a_eval_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> dp_cmd.start)
    else $error("accepted command was not evaluated");

endmodule

`default_nettype wire

@@ design/iids_datapath.sv @@
// Datapath of the indexed insert/delete stack: entry memory, count, move pointers
// and result registers. Uses iids_pkg for codes and the controller interface types.
`default_nettype none

module iids_datapath #(
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire logic [1:0]          in_cmd,
  input  wire logic signed [31:0]  in_value,
  input  wire logic [4:0]          in_position,
  input  wire iids_pkg::dp_cmd_t   dp_cmd,
  output iids_pkg::dp_stat_t       dp_stat,
  output logic signed [31:0]       out_popped_value,
  output logic [1:0]               out_status,
  output logic [4:0]               out_count
);
  import iids_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  // Stack storage; the bottom entry lives at address 0.
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  // Latched command.
  logic [1:0]         cmd_r;
  logic signed [31:0] value_r;
  logic [4:0]         pos_r;

  // Control state.
  logic [CW-1:0] cnt_r;
  logic          wr_pend_r;

  // Move sequencing.
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] wr_addr_r;
  logic [AW-1:0] t_r;
  logic [4:0]    rem_r;
  logic          dir_up_r;

  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] base_ext;
  logic [CMPW-1:0] top_ext;
  logic [CMPW-1:0] cnt_new_ext;
  logic [4:0]      mpos;
  logic [1:0]      status;
  logic            is_put;
  logic            is_take;
  logic [AW-1:0]   base_addr;
  logic [AW-1:0]   top_addr;
  logic            mem_rd_en;
  logic [AW-1:0]   mem_rd_addr;
  logic            mem_wr_en;
  logic [AW-1:0]   mem_wr_addr;
  logic signed [31:0] mem_wr_data;

  // Input latch.
  always_ff @(posedge clk) begin
    if (dp_cmd.cap) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
      pos_r   <= in_position;
    end
  end

  // Decode the latched command against the current count.
  always_comb begin
    cnt_ext = CMPW'(cnt_r);
    pos_ext = CMPW'(pos_r);
    is_put  = (cmd_r == CMD_PUSH) || (cmd_r == CMD_INSERT);
    is_take = !is_put;
    mpos    = ((cmd_r == CMD_INSERT) || (cmd_r == CMD_REMOVE)) ? pos_r : 5'd0;
    status  = ST_OK;
    case (cmd_r)
      CMD_PUSH: begin
        if (cnt_ext == CMPW'(DEPTH)) status = ST_FULL;
      end
      CMD_POP: begin
        if (cnt_ext == '0) status = ST_EMPTY;
      end
      CMD_INSERT: begin
        if (pos_ext > cnt_ext) status = ST_RANGE;
        else if (cnt_ext == CMPW'(DEPTH)) status = ST_FULL;
      end
      CMD_REMOVE: begin
        if (pos_ext == '0) begin
          if (cnt_ext == '0) status = ST_EMPTY;
        end else if (!(pos_ext < cnt_ext)) begin
          status = ST_RANGE;
        end
      end
      default: status = ST_OK;
    endcase
  end

  // Address arithmetic: the word at position p sits at address count-1-p.
  assign base_ext  = cnt_ext - CMPW'(mpos);
  assign top_ext   = cnt_ext - CMPW'(1);
  assign base_addr = base_ext[AW-1:0];
  assign top_addr  = top_ext[AW-1:0];

  // Count after the command.
  always_comb begin
    cnt_new_ext = cnt_ext;
    if (status == ST_OK) begin
      if (is_put) cnt_new_ext = cnt_ext + CMPW'(1);
      else if (is_take) cnt_new_ext = cnt_ext - CMPW'(1);
    end
  end

  assign dp_stat.status    = status;
  assign dp_stat.is_put    = is_put;
  assign dp_stat.is_pop    = (cmd_r == CMD_POP);
  assign dp_stat.no_moves  = (mpos == 5'd0);
  assign dp_stat.last_move = (rem_r == 5'd1);

  // Move pointers; a put walks down from the top, a take walks up.
  always_ff @(posedge clk) begin
    if (dp_cmd.start) begin
      rem_r    <= mpos;
      rd_ptr_r <= is_put ? top_addr : base_addr;
      t_r      <= base_addr;
      dir_up_r <= is_take;
    end else if (dp_cmd.shift_rd) begin
      rem_r     <= rem_r - 5'd1;
      rd_ptr_r  <= dir_up_r ? (rd_ptr_r + AW'(1)) : (rd_ptr_r - AW'(1));
      wr_addr_r <= dir_up_r ? (rd_ptr_r - AW'(1)) : (rd_ptr_r + AW'(1));
    end
  end

  // Each move read is followed by a pending write of its registered read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= dp_cmd.shift_rd;
    end
  end

  // Memory port selection.
  assign mem_rd_en   = dp_cmd.shift_rd || dp_cmd.pop_rd;
  assign mem_rd_addr = dp_cmd.pop_rd ? top_addr : rd_ptr_r;
  assign mem_wr_en   = wr_pend_r || dp_cmd.place;
  assign mem_wr_addr = wr_pend_r ? wr_addr_r : t_r;
  assign mem_wr_data = wr_pend_r ? rd_data_r : value_r;

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_wr_en) mem[mem_wr_addr] <= mem_wr_data;
    if (mem_rd_en) rd_data_r <= mem[mem_rd_addr];
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (dp_cmd.finish) begin
      cnt_r <= cnt_new_ext[CW-1:0];
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (dp_cmd.finish) begin
      out_popped_value <= ((cmd_r == CMD_POP) && (status == ST_OK)) ? rd_data_r : 32'sd0;
      out_status       <= status;
      out_count        <= cnt_new_ext[4:0];
    end
  end

endmodule

`default_nettype wire

@@ design/iids_ctrl.sv @@
// Controller of the indexed insert/delete stack: sequences each command through
// evaluation, entry moves, placement and result delivery. Uses iids_pkg types.
`default_nettype none

module iids_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire                     out_stall,
  input  wire iids_pkg::dp_stat_t dp_stat,
  output iids_pkg::dp_cmd_t       dp_cmd
);
  import iids_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.cap = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        dp_cmd.start = 1'b1;
        if (dp_stat.status != ST_OK) begin
          state_nxt = S_DONE;
        end else if (dp_stat.is_pop) begin
          dp_cmd.pop_rd = 1'b1;
          state_nxt     = S_DONE;
        end else if (dp_stat.no_moves) begin
          state_nxt = dp_stat.is_put ? S_PLACE : S_DONE;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        dp_cmd.shift_rd = 1'b1;
        if (dp_stat.last_move) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = dp_stat.is_put ? S_PLACE : S_DONE;
      end
      S_PLACE: begin
        dp_cmd.place = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          dp_cmd.finish = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The result register fills on finish and empties on a transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.finish) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire
